FILE: rtl/oaht_pkg.sv
// Shared types and constants of the open-addressing hash table core.
package oaht_pkg;

    localparam int KEY_W    = 28;
    localparam int MULT_W   = 16;
    localparam int BITS_W   = 3;
    localparam int STEP_W   = 7;
    localparam int SLOT_W   = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_BITS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_STEP      = 2'd2;

    localparam logic [MULT_W-1:0] HASH_MULTIPLIER_RST = 16'd40503;
    localparam logic [BITS_W-1:0] HASH_BITS_RST       = 3'd3;
    localparam logic [STEP_W-1:0] PROBE_STEP_RST      = 7'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] search_key;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } rsp_word_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
    } slot_entry_t;

endpackage

FILE: rtl/open_addressing_hash_table_core.sv
// Top level of the open-addressing hash table: command engine around the slot memory.
// A command probes n slots (1..TABLE_SIZE) before its response word; an unknown command
// answers without probing. One command at a time: the next request word is taken in the
// cycle after the response word is loaded.
// The rate is set by the single read port of the slot memory, one probe per cycle.
// Reset: a clearing pass empties every slot; requests stall meanwhile.
module open_addressing_hash_table_core
    import oaht_pkg::*;
#(
    parameter int TABLE_SIZE = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_word_t             req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_word_t             rsp_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HOME,
        ST_PROBE,
        ST_REPLY
    } state_t;

    function automatic logic [SLOT_W-1:0] mod_table(input logic [SLOT_W-1:0] v);
        logic [SLOT_W-1:0] r;
        r = v;
        if (TABLE_SIZE < 128)
        begin
            for (int j = 3; j >= 0; j--)
            begin
                if ({9'b0, r} >= 16'(TABLE_SIZE << j))
                begin
                    r = r - SLOT_W'(TABLE_SIZE << j);
                end
            end
        end
        return r;
    endfunction

    logic [MULT_W-1:0] hash_multiplier_reg;
    logic [BITS_W-1:0] hash_bits_reg;
    logic [STEP_W-1:0] probe_step_reg;

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [MULT_W-1:0] prod_reg, prod_next;
    logic [ADDR_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] chk_slot_reg, chk_slot_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]  check_cnt_reg, check_cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    rsp_word_t         result_reg, result_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_data_reg, rsp_data_next;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    slot_entry_t       ram_wr_data;
    logic              ram_rd_en;
    slot_entry_t       ram_rd_data;

    logic [SLOT_W-1:0] home_raw;
    logic [ADDR_W:0]   slot_sum;
    logic [ADDR_W-1:0] slot_adv;
    logic              hit;
    logic              cmd_known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_multiplier_reg <= HASH_MULTIPLIER_RST;
            hash_bits_reg       <= HASH_BITS_RST;
            probe_step_reg      <= PROBE_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_HASH_MULTIPLIER: hash_multiplier_reg <= cfg_data;
                CFG_HASH_BITS:       hash_bits_reg       <= cfg_data[BITS_W-1:0];
                CFG_PROBE_STEP:      probe_step_reg      <= cfg_data[STEP_W-1:0];
                default:             ;
            endcase
        end
    end

    assign home_raw  = SLOT_W'(prod_reg >> (5'd16 - {2'b0, hash_bits_reg}));
    assign slot_sum  = {1'b0, cur_reg} + {1'b0, step_reg};
    assign slot_adv  = (slot_sum >= (ADDR_W+1)'(TABLE_SIZE))
                     ? ADDR_W'(slot_sum - (ADDR_W+1)'(TABLE_SIZE))
                     : ADDR_W'(slot_sum);
    assign hit       = (cmd_reg == CMD_INSERT) ? !ram_rd_data.used
                     : (ram_rd_data.used && (ram_rd_data.key == key_reg));
    assign cmd_known = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_SEARCH)
                     || (cmd_reg == CMD_DELETE);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        prod_next      = prod_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        chk_slot_next  = chk_slot_reg;
        issue_cnt_next = issue_cnt_reg;
        check_cnt_next = check_cnt_reg;
        rd_pend_next   = 1'b0;
        clr_cnt_next   = clr_cnt_reg;
        result_next    = result_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        ram_rd_en      = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = chk_slot_reg;
        ram_wr_data    = '{used: (cmd_reg == CMD_INSERT), key: key_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req_data.command;
                    key_next   = req_data.search_key;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                prod_next  = MULT_W'(key_reg[MULT_W-1:0] * hash_multiplier_reg);
                step_next  = ADDR_W'(mod_table(probe_step_reg));
                state_next = ST_HOME;
            end
            ST_HOME:
            begin
                cur_next       = ADDR_W'(mod_table(home_raw));
                issue_cnt_next = '0;
                check_cnt_next = '0;
                if (cmd_known)
                begin
                    state_next = ST_PROBE;
                end
                else
                begin
                    result_next = '{status: STATUS_NOT_FOUND, slot: '0};
                    state_next  = ST_REPLY;
                end
            end
            ST_PROBE:
            begin
                if (issue_cnt_reg != CNT_W'(TABLE_SIZE))
                begin
                    ram_rd_en      = 1'b1;
                    rd_pend_next   = 1'b1;
                    chk_slot_next  = cur_reg;
                    cur_next       = slot_adv;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    check_cnt_next = check_cnt_reg + 1'b1;
                    if (hit)
                    begin
                        ram_wr_en   = (cmd_reg != CMD_SEARCH);
                        result_next = '{status: STATUS_DONE, slot: SLOT_W'(chk_slot_reg)};
                        state_next  = ST_REPLY;
                    end
                    else if (check_cnt_reg == CNT_W'(TABLE_SIZE - 1))
                    begin
                        result_next.status = (cmd_reg == CMD_INSERT) ? STATUS_FULL
                                                                     : STATUS_NOT_FOUND;
                        result_next.slot   = '0;
                        state_next         = ST_REPLY;
                    end
                end
            end
            ST_REPLY:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            issue_cnt_reg <= '0;
            check_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            check_cnt_reg <= check_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        prod_reg     <= prod_next;
        step_reg     <= step_next;
        cur_reg      <= cur_next;
        chk_slot_reg <= chk_slot_next;
        result_reg   <= result_next;
        rsp_data_reg <= rsp_data_next;
    end

    oaht_slot_ram #(
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cur_reg),
        .rd_data (ram_rd_data)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef ASSERT_OFF
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status == STATUS_DONE || rsp_data.slot == '0))
        else $error("failed command reports a nonzero slot");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_PROBE))
        else $error("slot memory written outside clear or probe");

    a_check_behind_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (check_cnt_reg <= issue_cnt_reg))
        else $error("more probes checked than issued");

    a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(ram_rd_en))
        else $error("read data marked pending without a read");
`endif

endmodule

FILE: rtl/oaht_slot_ram.sv
// Slot memory: one write port and one registered read port.
module oaht_slot_ram
    import oaht_pkg::*;
#(
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_entry_t       rd_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
